// ===== hw/rtl/multichannel_moving_average_unit_assert.svh =====
// Assertion helpers for the moving average unit.
`ifndef MULTICHANNEL_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_UNIT_ASSERT_SVH

// Clocked check, held off while reset is asserted.
`define MMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define MMA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/mma_pkg.sv =====
package mma_pkg;

  // One input transfer: a sample for one channel.
  typedef struct packed {
    logic [2:0] channel;
    logic [7:0] sample;
  } in_item_t;

  // One result transfer: the channel and its current average.
  typedef struct packed {
    logic [2:0] channel_out;
    logic [7:0] average;
  } out_item_t;

endpackage

// ===== hw/rtl/mma_stream_if.sv =====
interface mma_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/multichannel_moving_average_unit.sv =====
// Boxcar moving average over CHANNELS independent channels of WINDOW samples.
// Channel state is read at input transfer, S_RDST reads the oldest sample,
// S_RDSMP writes back and loads the bit-serial divider, S_DIV divides, S_FIN
// loads the result; out-of-range channels skip to S_FIN. One item in flight.
// A finished result waits in the output register while the next item runs.
// Reset (async, active low) clears the channel valid flags at once, so fill counts, sums and positions read as zero.
`include "multichannel_moving_average_unit_assert.svh"

module multichannel_moving_average_unit #(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mma_stream_if.sink   sample_i,
  mma_stream_if.source result_o
);
  import mma_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * 255 + 1);
  localparam int STEP_W = $clog2(SUM_W);
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ST_W   = POS_W + CNT_W + SUM_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDST  = 3'd1;
  localparam logic [2:0] S_RDSMP = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [2:0]        ch_q;
  logic [7:0]        smp_q;
  logic              valid_q [CHANNELS];
  logic [ST_W-1:0]   st_mem [CHANNELS];
  logic [7:0]        smp_mem [DEPTH];
  logic [ST_W-1:0]   st_rd_q;
  logic              st_vld_q;
  logic [7:0]        old_smp_q;
  logic [CNT_W-1:0]  rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  dsr_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              in_xfer;
  logic              in_range;
  logic [CH_W-1:0]   in_idx;
  logic [CH_W-1:0]   ch_idx;
  logic [POS_W-1:0]  cur_pos, new_pos;
  logic [CNT_W-1:0]  cur_cnt, new_cnt;
  logic [SUM_W-1:0]  cur_sum, new_sum;
  logic              full;
  logic [ADDR_W-1:0] smp_addr;
  logic [CNT_W:0]    shifted;
  logic              ge;
  logic              out_load;

  assign in_xfer  = sample_i.valid && sample_i.ready;
  assign in_range = 32'(sample_i.payload.channel) < CHANNELS;
  assign in_idx   = CH_W'(sample_i.payload.channel);
  assign ch_idx   = CH_W'(ch_q);

  assign sample_i.ready  = (state_q == S_IDLE);
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // Channel state as read; a channel never written reads as zero
  assign cur_pos = st_vld_q ? st_rd_q[ST_W-1 -: POS_W]         : '0;
  assign cur_cnt = st_vld_q ? st_rd_q[SUM_W +: CNT_W]          : '0;
  assign cur_sum = st_vld_q ? st_rd_q[SUM_W-1:0]               : '0;

  // Window update
  assign full     = (cur_cnt == CNT_W'(WINDOW));
  assign new_sum  = cur_sum + SUM_W'(smp_q) - (full ? SUM_W'(old_smp_q) : '0);
  assign new_cnt  = full ? cur_cnt : cur_cnt + 1'b1;
  assign new_pos  = (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
  assign smp_addr = ADDR_W'(ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(cur_pos);

  // Restoring divider step
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign ge      = shifted >= {1'b0, dsr_q};

  assign out_load = (state_q == S_FIN) && (!out_valid_q || result_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = in_range ? S_RDST : S_FIN;
      end
      S_RDST:  state_d = S_RDSMP;
      S_RDSMP: state_d = S_DIV;
      S_DIV: begin
        if (step_q == '0) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) valid_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_RDSMP) valid_q[ch_idx] <= 1'b1;
    end
  end

  // Item capture and channel state read
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q  <= sample_i.payload.channel;
      smp_q <= sample_i.payload.sample;
      if (in_range) begin
        st_rd_q  <= st_mem[in_idx];
        st_vld_q <= valid_q[in_idx];
      end
    end
  end

  // Channel state write-back
  always_ff @(posedge clk_i) begin
    if (state_q == S_RDSMP) st_mem[ch_idx] <= {new_pos, new_cnt, new_sum};
  end

  // Sample ring: read oldest, then overwrite it
  always_ff @(posedge clk_i) begin
    if (state_q == S_RDST) old_smp_q <= smp_mem[smp_addr];
    if (state_q == S_RDSMP) smp_mem[smp_addr] <= smp_q;
  end

  // Divider datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer && !in_range) begin
      quo_q <= '0;
    end else if (state_q == S_RDSMP) begin
      rem_q  <= '0;
      quo_q  <= new_sum;
      dsr_q  <= new_cnt;
      step_q <= STEP_W'(SUM_W - 1);
    end else if (state_q == S_DIV) begin
      rem_q  <= ge ? CNT_W'(shifted - {1'b0, dsr_q}) : CNT_W'(shifted);
      quo_q  <= {quo_q[SUM_W-2:0], ge};
      step_q <= step_q - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.channel_out <= ch_q;
      out_q.average     <= quo_q[7:0];
    end
  end

  `MMA_ASSERT(a_rem_below_divisor, (state_q == S_DIV) |-> (rem_q < dsr_q),
              "divider remainder reached the divisor")
  `MMA_ASSERT(a_quo_fits, (state_q == S_FIN) |-> (quo_q <= SUM_W'(255)),
              "average exceeds eight bits")
  `MMA_ASSERT(a_cnt_bound, (state_q == S_RDSMP) |-> (new_cnt <= CNT_W'(WINDOW)),
              "fill count beyond window")
  `MMA_ASSERT(a_result_from_fin, $rose(out_valid_q) |-> ($past(state_q) == S_FIN),
              "result raised outside finish state")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mma_pkg::*;

  localparam int CHANNELS    = 8;
  localparam int WINDOW      = 16;
  localparam int RAND_ITEMS  = 600;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 24;

  // Idle pattern applied while a group of samples is in flight
  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    in_item_t   item;
    idle_mode_e mode;
  } pending_sample_t;

  logic clk_i;
  logic rst_ni;

  mma_stream_if #(.payload_t(in_item_t))  sample_if ();
  mma_stream_if #(.payload_t(out_item_t)) result_if ();

  multichannel_moving_average_unit #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .result_o(result_if)
  );

  // Samples waiting to go out, and averages waiting to come back
  pending_sample_t samples_to_send[$];
  out_item_t       averages_due[$];
  idle_mode_e      cur_mode;

  // Shadow copy of the per-channel windows
  logic [7:0]  win_samples [CHANNELS][WINDOW];
  logic [3:0]  win_pos     [CHANNELS];
  logic [4:0]  win_fill    [CHANNELS];
  logic [11:0] win_sum     [CHANNELS];

  int unsigned samples_sent;
  int unsigned averages_checked;
  int unsigned mismatches;
  int unsigned stall_cycles;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_pct(idle_mode_e mode, bit receiver);
    case (mode)
      IDLE_SENDER:   return receiver ? 0 : 49;
      IDLE_RECEIVER: return receiver ? 49 : 0;
      IDLE_BOTH:     return 17;
      default:       return 0;
    endcase
  endfunction

  // Advance one channel's window and return the average it now holds
  function automatic out_item_t average_after(in_item_t item);
    out_item_t  res;
    int unsigned ch;
    int unsigned pos;
    int unsigned sum;
    ch  = item.channel;
    res.channel_out = item.channel;
    res.average     = '0;
    if (ch < CHANNELS) begin
      pos = win_pos[ch];
      sum = win_sum[ch] + item.sample;
      // full window: the oldest sample drops out
      if (win_fill[ch] == WINDOW) sum = sum - win_samples[ch][pos];
      win_samples[ch][pos] = item.sample;
      win_pos[ch]  = (pos == WINDOW - 1) ? 4'd0 : 4'(pos + 1);
      if (win_fill[ch] < WINDOW) win_fill[ch] = win_fill[ch] + 5'd1;
      win_sum[ch]  = 12'(sum);
      res.average  = 8'(sum / win_fill[ch]);
    end
    return res;
  endfunction

  function automatic void queue_sample(int unsigned ch, int unsigned smp, idle_mode_e mode);
    pending_sample_t p;
    p.item.channel = 3'(ch);
    p.item.sample  = 8'(smp);
    p.mode         = mode;
    samples_to_send.push_back(p);
  endfunction

  // Driver: offers queued samples, predicts the average on each transfer
  always @(posedge clk_i or negedge rst_ni) begin : drv
    pending_sample_t nxt;
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        averages_due.push_back(average_after(sample_if.payload));
        samples_sent <= samples_sent + 1;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (samples_to_send.size() != 0 &&
            $urandom_range(99) >= idle_pct(samples_to_send[0].mode, 1'b0)) begin
          nxt = samples_to_send.pop_front();
          sample_if.valid   <= 1'b1;
          sample_if.payload <= nxt.item;
          cur_mode          <= nxt.mode;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : mon
    out_item_t exp_avg;
    bit        bad;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (averages_due.size() == 0) begin
          $error("unexpected result: channel_out %0d average %0d",
                 result_if.payload.channel_out, result_if.payload.average);
          mismatches <= mismatches + 1;
        end else begin
          exp_avg = averages_due.pop_front();
          averages_checked <= averages_checked + 1;
          bad = 1'b0;
          if (result_if.payload.channel_out !== exp_avg.channel_out) begin
            $error("channel_out mismatch: expected %0d, actual %0d",
                   exp_avg.channel_out, result_if.payload.channel_out);
            bad = 1'b1;
          end
          if (result_if.payload.average !== exp_avg.average) begin
            $error("average mismatch: expected %0d, actual %0d",
                   exp_avg.average, result_if.payload.average);
            bad = 1'b1;
          end
          if (bad) mismatches <= mismatches + 1;
        end
      end
      result_if.ready <= ($urandom_range(99) >= idle_pct(cur_mode, 1'b1));
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stim
    int unsigned n;
    int unsigned ch;
    int unsigned len;
    int unsigned kind;
    int unsigned smp;
    idle_mode_e  mode;

    rst_ni            = 1'b0;
    sample_if.valid   = 1'b0;
    sample_if.payload = '0;
    result_if.ready   = 1'b0;
    cur_mode          = IDLE_NONE;
    samples_sent      = 0;
    averages_checked  = 0;
    mismatches        = 0;
    stall_cycles      = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      win_pos[c]  = '0;
      win_fill[c] = '0;
      win_sum[c]  = '0;
    end

    // Directed: fill channel 7 at full scale past the window so it wraps
    for (int i = 0; i <= WINDOW; i++) queue_sample(7, 255, IDLE_NONE);
    // lowest channel, zero, mid scale, warm-up averages with fractions
    queue_sample(0, 0, IDLE_NONE);
    queue_sample(0, 128, IDLE_NONE);
    queue_sample(0, 1, IDLE_NONE);
    queue_sample(5, 170, IDLE_NONE);
    queue_sample(5, 85, IDLE_NONE);
    queue_sample(2, 254, IDLE_NONE);

    // Random: channel bursts that warm up and wrap windows, plus scattered samples
    n = 0;
    while (n < RAND_ITEMS) begin
      mode = idle_mode_e'(((n * 8) / RAND_ITEMS) % 4);
      if ($urandom_range(99) < 75) begin
        ch   = $urandom_range(CHANNELS - 1);
        len  = $urandom_range(24, 1);
        kind = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
          case (kind)
            0:       smp = $urandom_range(1) ? 255 : 0;
            1:       smp = $urandom_range(255, 224);
            default: smp = $urandom_range(255);
          endcase
          queue_sample(ch, smp, mode);
        end
        n += len;
      end else begin
        queue_sample($urandom_range(CHANNELS - 1), $urandom_range(255), mode);
        n++;
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (samples_to_send.size() != 0 || sample_if.valid) @(posedge clk_i);
    while (averages_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("tb: %0d samples over %0d channels, %0d averages checked, %0d mismatches",
             samples_sent, CHANNELS, averages_checked, mismatches);
    $display("tb: covered window warm-up and wrap, full-scale sums, all four idle patterns");
    if (mismatches == 0 && averages_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mma_pkg.sv
hw/rtl/mma_stream_if.sv
hw/rtl/multichannel_moving_average_unit.sv
tb/sv/tb.sv
